// ===== src/pli_pkg.sv =====
package pli_pkg;

  localparam int MAX_POINTS = 16;

  // product of a 32 bit offset and a 33 bit magnitude
  localparam int PROD_W = 65;
  // quotient stays below the 33 bit magnitude
  localparam int QUOT_W = 33;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_CLAMP,
    MODE_LERP
  } mode_e;

  typedef struct packed {
    logic        valid;
    mode_e       mode;
    logic [31:0] yc;
    logic [31:0] y1;
    logic        neg;
  } side_t;

endpackage

// ===== src/pli_div.sv =====
module pli_div import pli_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  side_t               side_i,
  input  logic [PROD_W-1:0]   prod_i,
  input  logic [31:0]         den_i,
  output side_t               side_o,
  output logic [QUOT_W-1:0]   quot_o
);

  // one quotient bit per stage, restoring long division
  localparam int Steps = QUOT_W;

  for (genvar s = 0; s < Steps; s++) begin : g_step
    side_t             side_in;
    logic [31:0]       rem_in;
    logic [QUOT_W-1:0] low_in;
    logic [QUOT_W-1:0] quo_in;
    logic [31:0]       den_in;
    logic [32:0]       trial;
    logic [31:0]       diff;
    logic              take;
    side_t             side_d;
    logic [31:0]       rem_d;
    logic [QUOT_W-1:0] low_d;
    logic [QUOT_W-1:0] quo_d;
    side_t             side_q;
    logic [31:0]       rem_q;
    logic [QUOT_W-1:0] low_q;
    logic [QUOT_W-1:0] quo_q;
    logic [31:0]       den_q;

    if (s == 0) begin : g_head
      // the upper part of the product is already below the divisor
      assign side_in = side_i;
      assign rem_in  = prod_i[PROD_W-1:QUOT_W];
      assign low_in  = prod_i[QUOT_W-1:0];
      assign quo_in  = '0;
      assign den_in  = den_i;
    end else begin : g_body
      assign side_in = g_step[s-1].side_q;
      assign rem_in  = g_step[s-1].rem_q;
      assign low_in  = g_step[s-1].low_q;
      assign quo_in  = g_step[s-1].quo_q;
      assign den_in  = g_step[s-1].den_q;
    end

    always_comb begin
      trial  = {rem_in, low_in[QUOT_W-1]};
      diff   = trial[31:0] - den_in;
      take   = trial >= {1'b0, den_in};
      rem_d  = take ? diff : trial[31:0];
      low_d  = {low_in[QUOT_W-2:0], 1'b0};
      quo_d  = {quo_in[QUOT_W-2:0], take};
      side_d = side_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q <= '0;
      end else if (en_i) begin
        side_q <= side_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= rem_d;
        low_q <= low_d;
        quo_q <= quo_d;
        den_q <= den_in;
      end
    end
  end

  assign side_o = g_step[Steps-1].side_q;
  assign quot_o = g_step[Steps-1].quo_q;

endmodule

// ===== src/piecewise_linear_interpolator.sv =====
// channel   direction  handshake                   payload
// in        input      in_valid_i / in_stall_o     req_type_i point_index_i point_x_i
//                                                  point_y_i sample_x_i
// out       output     out_valid_o / out_stall_i   y_out_o updated_o
// config    input      num_points_we_i             num_points_i
//
// an evaluate result is offered once its request has passed through the registered stages: compare,
// segment select, differences, multiply, 33 divider stages (one quotient bit each)
// and the output register.
// a request may enter every cycle while in_stall_o is low; write requests update the table at once and
// produce no result.
// reset clears the point count, the held output and all valid bits; table holds
// garbage until written. a stalled output freezes the whole pipeline.
module piecewise_linear_interpolator import pli_pkg::*; #(
  parameter int MaxPoints = MAX_POINTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               num_points_we_i,
  input  logic [4:0]         num_points_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [3:0]         point_index_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] sample_x_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] y_out_o,
  output logic               updated_o
);

  localparam int IdxW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int CntW = $clog2(MaxPoints + 1);

  logic              adv;
  logic [4:0]        num_points_q;
  logic [CntW-1:0]   cnt;
  logic signed [31:0] bp_x_q [MaxPoints];
  logic signed [31:0] bp_y_q [MaxPoints];
  logic              wr_en;
  logic [IdxW-1:0]   wr_idx;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= '0;
    end else if (num_points_we_i) begin
      num_points_q <= num_points_i;
    end
  end

  assign cnt = (int'(num_points_q) > MaxPoints) ? CntW'(MaxPoints) : CntW'(num_points_q);

  assign wr_en  = in_valid_i && adv && !req_type_i && (int'(point_index_i) < MaxPoints);
  assign wr_idx = IdxW'(point_index_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bp_x_q[wr_idx] <= point_x_i;
      bp_y_q[wr_idx] <= point_y_i;
    end
  end

  // stage 1: compare the sample against every breakpoint in use
  logic [MaxPoints-1:0] lt;
  logic                 s1_valid_q;
  logic [MaxPoints-1:0] s1_lt_q;
  logic signed [31:0]   s1_x_q;
  logic [CntW-1:0]      s1_cnt_q;

  always_comb begin
    for (int k = 0; k < MaxPoints; k++) begin
      lt[k] = (sample_x_i < bp_x_q[k]) && (k < int'(cnt));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i && req_type_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_lt_q  <= lt;
      s1_x_q   <= sample_x_i;
      s1_cnt_q <= cnt;
    end
  end

  // stage 2: first breakpoint above the sample picks the segment
  logic            found;
  logic [IdxW-1:0] hit;
  logic [IdxW-1:0] hit_m1;
  logic [IdxW-1:0] last;
  side_t           s2_side_d;
  side_t           s2_side_q;
  logic signed [31:0] s2_x_q, s2_x1_q, s2_x2_q, s2_y2_q;

  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int i = MaxPoints - 1; i >= 0; i--) begin
      if (s1_lt_q[i]) begin
        found = 1'b1;
        hit   = IdxW'(i);
      end
    end
    hit_m1 = hit - IdxW'(1);
    last   = IdxW'(s1_cnt_q - CntW'(1));
  end

  always_comb begin
    s2_side_d       = '0;
    s2_side_d.valid = s1_valid_q;
    s2_side_d.y1    = bp_y_q[hit_m1];
    s2_side_d.yc    = bp_y_q[last];
    s2_side_d.neg   = 1'b0;
    if (s1_cnt_q < CntW'(2)) begin
      s2_side_d.mode = MODE_HOLD;
    end else if (!found) begin
      s2_side_d.mode = MODE_CLAMP;
    end else if (hit == '0) begin
      s2_side_d.mode = MODE_CLAMP;
      s2_side_d.yc   = bp_y_q[0];
    end else begin
      s2_side_d.mode = MODE_LERP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_side_q <= '0;
    end else if (adv) begin
      s2_side_q <= s2_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_x_q  <= s1_x_q;
      s2_x1_q <= bp_x_q[hit_m1];
      s2_x2_q <= bp_x_q[hit];
      s2_y2_q <= bp_y_q[hit];
    end
  end

  // stage 3: offsets and the sign/magnitude of the y difference
  logic [31:0] num, den;
  logic [32:0] dy, mag;
  side_t       s3_side_d, s3_side_q;
  logic [31:0] s3_num_q, s3_den_q;
  logic [32:0] s3_mag_q;

  always_comb begin
    num           = 32'(s2_x_q - s2_x1_q);
    den           = 32'(s2_x2_q - s2_x1_q);
    dy            = {s2_y2_q[31], s2_y2_q} - {s2_side_q.y1[31], s2_side_q.y1};
    mag           = dy[32] ? (33'd0 - dy) : dy;
    s3_side_d     = s2_side_q;
    s3_side_d.neg = dy[32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_side_q <= '0;
    end else if (adv) begin
      s3_side_q <= s3_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_num_q <= num;
      s3_den_q <= den;
      s3_mag_q <= mag;
    end
  end

  // stage 4: multiply
  side_t             s4_side_q;
  logic [PROD_W-1:0] s4_prod_q;
  logic [31:0]       s4_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_side_q <= '0;
    end else if (adv) begin
      s4_side_q <= s3_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_prod_q <= PROD_W'(s3_num_q) * PROD_W'(s3_mag_q);
      s4_den_q  <= s3_den_q;
    end
  end

  side_t             dv_side;
  logic [QUOT_W-1:0] dv_quot;

  pli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .side_i (s4_side_q),
    .prod_i (s4_prod_q),
    .den_i  (s4_den_q),
    .side_o (dv_side),
    .quot_o (dv_quot)
  );

  // final stage: apply the quotient, resolve held output in request order
  logic [33:0] y_ext;
  logic [31:0] y_res;
  logic        out_valid_q;
  logic [31:0] y_out_q, held_q;
  logic        updated_q;

  always_comb begin
    y_ext = dv_side.neg ? ({{2{dv_side.y1[31]}}, dv_side.y1} - {1'b0, dv_quot})
                        : ({{2{dv_side.y1[31]}}, dv_side.y1} + {1'b0, dv_quot});
    case (dv_side.mode)
      MODE_HOLD:  y_res = held_q;
      MODE_CLAMP: y_res = dv_side.yc;
      MODE_LERP:  y_res = y_ext[31:0];
      default:    y_res = held_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else if (adv) begin
      out_valid_q <= dv_side.valid;
      if (dv_side.valid && dv_side.mode != MODE_HOLD) begin
        held_q <= y_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_out_q   <= y_res;
      updated_q <= dv_side.mode != MODE_HOLD;
    end
  end

  assign out_valid_o = out_valid_q;
  assign y_out_o     = y_out_q;
  assign updated_o   = updated_q;

endmodule
